>>> rtl/msp_pkg.sv
// shared types and constants for the min tracking stack
// no dependencies; imported by every module of the block
package msp_pkg;

  // default stack depth
  localparam int unsigned DepthDef = 64;

  // data word width
  localparam int unsigned DataW = 32;

  // operation codes
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic push;
    logic pop;
    logic load_top;
    logic load_out;
    logic ignored;
  } msp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
  } msp_status_t;

endpackage

>>> rtl/msp_ctrl.sv
// controller state machine of the min tracking stack
// depends on msp_pkg; drives commands into msp_datapath
module msp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          op_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  msp_pkg::msp_status_t status_i,
  output msp_pkg::msp_cmd_t    cmd_o
);
  import msp_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOAD   = 2'd1;
  localparam logic [1:0] ST_RESULT = 2'd2;

  logic [1:0] state_q, state_d;
  logic       ignored_q, ignored_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       out_free;

  assign accept   = (state_q == ST_IDLE) && in_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;

  // next state and commands
  always_comb begin
    state_d       = state_q;
    ignored_d     = ignored_q;
    cmd_o         = '0;
    cmd_o.ignored = ignored_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ignored_d = 1'b0;
          state_d   = ST_RESULT;
          case (op_i)
            OP_PUSH: begin
              if (status_i.full) begin
                ignored_d = 1'b1;
              end else begin
                cmd_o.push = 1'b1;
              end
            end
            OP_POP: begin
              if (status_i.empty) begin
                ignored_d = 1'b1;
              end else begin
                cmd_o.pop = 1'b1;
                state_d   = ST_LOAD;
              end
            end
            default: begin
              // peek and the unused code change nothing
            end
          endcase
        end
      end
      ST_LOAD: begin
        cmd_o.load_top = 1'b1;
        state_d        = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output word valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ignored_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ignored_q   <= ignored_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/msp_datapath.sv
// datapath of the min tracking stack: top registers, stack memory, output word
// depends on msp_pkg; commanded by msp_ctrl
module msp_datapath #(
  parameter int unsigned Depth = msp_pkg::DepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  msp_pkg::msp_cmd_t          cmd_i,
  output msp_pkg::msp_status_t       status_o,
  input  logic signed [msp_pkg::DataW-1:0] push_value_i,
  output logic signed [msp_pkg::DataW-1:0] top_value_o,
  output logic signed [msp_pkg::DataW-1:0] min_value_o,
  output logic                       is_empty_o,
  output logic                       is_full_o,
  output logic                       ignored_o
);
  import msp_pkg::*;

  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountW = $clog2(Depth + 1);

  logic [CountW-1:0]       count_q, count_d;
  logic signed [DataW-1:0] top_q;
  logic signed [DataW-1:0] min_q;
  logic signed [DataW-1:0] rd_val_q;
  logic signed [DataW-1:0] rd_min_q;
  logic signed [DataW-1:0] new_min;
  logic [AddrW-1:0]        wr_addr;
  logic [AddrW-1:0]        rd_addr;
  logic                    empty;
  logic                    full;
  logic                    rd_en;

  // entries below the top, value and running minimum side by side
  logic signed [DataW-1:0] val_mem [Depth];
  logic signed [DataW-1:0] min_mem [Depth];

  assign empty   = (count_q == '0);
  assign full    = (count_q == CountW'(Depth));
  assign wr_addr = AddrW'(count_q - CountW'(1));
  assign rd_addr = AddrW'(count_q - CountW'(2));
  assign rd_en   = cmd_i.pop && (count_q >= CountW'(2));

  assign status_o.empty = empty;
  assign status_o.full  = full;

  // running minimum of the pushed word and everything below it
  assign new_min = (!empty && (min_q < push_value_i)) ? min_q : push_value_i;

  // entry count
  always_comb begin
    count_d = count_q;
    if (cmd_i.push) begin
      count_d = count_q + CountW'(1);
    end else if (cmd_i.pop) begin
      count_d = count_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // stack memory: spill the old top on push, registered read on pop
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && !empty) begin
      val_mem[wr_addr] <= top_q;
      min_mem[wr_addr] <= min_q;
    end
    if (rd_en) begin
      rd_val_q <= val_mem[rd_addr];
      rd_min_q <= min_mem[rd_addr];
    end
  end

  // top entry and its running minimum
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      top_q <= push_value_i;
      min_q <= new_min;
    end else if (cmd_i.load_top) begin
      top_q <= rd_val_q;
      min_q <= rd_min_q;
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      top_value_o <= empty ? '0 : top_q;
      min_value_o <= empty ? '0 : min_q;
      is_empty_o  <= empty;
      is_full_o   <= full;
      ignored_o   <= cmd_i.ignored;
    end
  end

endmodule

>>> rtl/min_tracking_stack.sv
// top level of the min tracking stack
// depends on msp_pkg, msp_ctrl and msp_datapath
//
// Bounded stack of signed 32-bit words that reports its smallest entry.
// Each input word is a push, a pop or a peek (the unused code acts as a
// peek) and gives exactly one output word with the new top, the minimum,
// the empty and full flags and an ignored flag for a push on full or a
// pop on empty. The top entry and its running minimum live in registers;
// the entries below sit in a single-port memory with a registered read.
// Push, peek and dropped operations go straight to the result state; a pop
// that succeeds first passes a load state to read the new top from memory.
// The result sits in an output register, so a new word is taken while the
// previous result is still stalled. No clearing pass is needed after reset.
module min_tracking_stack #(
  parameter int unsigned Depth = msp_pkg::DepthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       op_i,
  input  logic signed [msp_pkg::DataW-1:0] push_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [msp_pkg::DataW-1:0] top_value_o,
  output logic signed [msp_pkg::DataW-1:0] min_value_o,
  output logic                             is_empty_o,
  output logic                             is_full_o,
  output logic                             ignored_o
);
  import msp_pkg::*;

  msp_cmd_t    cmd;
  msp_status_t status;

  // controller
  msp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  msp_datapath #(
    .Depth(Depth)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .push_value_i(push_value_i),
    .top_value_o (top_value_o),
    .min_value_o (min_value_o),
    .is_empty_o  (is_empty_o),
    .is_full_o   (is_full_o),
    .ignored_o   (ignored_o)
  );

endmodule

>>> rtl/msp_checker.sv
// port level checks for the min tracking stack, bound to the top level
// depends on msp_pkg and min_tracking_stack
module msp_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic signed [msp_pkg::DataW-1:0] top_value_o,
  input logic signed [msp_pkg::DataW-1:0] min_value_o,
  input logic                             is_empty_o,
  input logic                             is_full_o,
  input logic                             ignored_o
);
  import msp_pkg::*;

  // an empty stack is never full
  a_empty_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_empty_o && is_full_o))
    else $error("empty and full together");

  // empty stack reads as zero
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_empty_o) |-> (top_value_o == '0 && min_value_o == '0))
    else $error("empty stack shows non-zero words");

  // minimum never above the top
  a_min_le_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_empty_o) |-> (min_value_o <= top_value_o))
    else $error("minimum above top");

  // one word at a time: taking a word stalls the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken back to back");

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(top_value_o) && $stable(min_value_o)
       && $stable(ignored_o)))
    else $error("stalled output word changed");

endmodule

bind min_tracking_stack msp_checker u_msp_checker (.*);
